[rtl/psg_tone_noise_core_defines.svh]
// Assertion macros shared by the tone and noise generator RTL.
// Depends on nothing; the files that assert take it by include.
`ifndef PSG_TONE_NOISE_CORE_DEFINES_SVH
`define PSG_TONE_NOISE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while the synchronous reset is held.
`define PSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psg assertion failed");

// Next-cycle implication, disabled while the synchronous reset is held.
`define PSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psg assertion failed");

`endif

[rtl/psg_pkg.sv]
// Shared types and constants of the tone and noise generator.
// Depends on nothing; every RTL module refers to it by scoped names.
`default_nettype none

package psg_pkg;

    localparam int NUM_TONES = 3;
    localparam int NUM_CHANS = 4;

    // Channel code of the noise channel.
    localparam logic [1:0] NOISE_CH = 2'd3;

    // Noise reload selection codes (noise control bits 1..0).
    localparam logic [1:0] NOISE_RATE_16  = 2'd0;
    localparam logic [1:0] NOISE_RATE_32  = 2'd1;
    localparam logic [1:0] NOISE_RATE_64  = 2'd2;
    localparam logic [1:0] NOISE_RATE_T2  = 2'd3;

    // Reset values.
    localparam logic [9:0]  PERIOD_RESET     = 10'h3ff;
    localparam logic [3:0]  ATTEN_RESET      = 4'hf;
    localparam logic [2:0]  NOISE_CTRL_RESET = 3'd7;
    localparam logic [15:0] COUNT_RESET      = 16'd1;
    localparam logic [19:0] RATIO_RESET      = 20'd20779;

    // Accumulator step per generator tick (128, one whole sample unit).
    localparam logic [20:0] RATE_STEP = 21'd128;

    // Configuration register index.
    localparam logic REG_SAMPLE_RATIO = 1'b0;

    // Control values handed from the register file to the counters.
    typedef struct packed {
        logic [NUM_TONES-1:0][9:0] period;
        logic [2:0]                noise_ctrl;
    } t_gen_cfg;

endpackage

`default_nettype wire

[rtl/psg_regs.sv]
// Bus write decoder and register file: latch state, periods, noise control, attenuation.
// Depends on psg_pkg.
`default_nettype none

module psg_regs (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_write_n,
    input  wire logic                   i_ioreq_n,
    input  wire logic [7:0]             i_port_address,
    input  wire logic [7:0]             i_write_data,
    output psg_pkg::t_gen_cfg           o_cfg_next,
    output logic [2:0]                  o_noise_ctrl,
    output logic [psg_pkg::NUM_CHANS-1:0][3:0] o_atten
);

    logic [psg_pkg::NUM_CHANS-1:0][3:0] r_atten, n_atten;
    logic [psg_pkg::NUM_TONES-1:0][9:0] r_period, n_period;
    logic [2:0] r_noise_ctrl, n_noise_ctrl;
    logic [1:0] r_latch_ch, n_latch_ch;
    logic       r_latch_vol, n_latch_vol;
    logic       wr;
    logic [1:0] tgt_ch;
    logic       tgt_vol;

    assign wr      = !i_write_n && !i_ioreq_n && i_port_address[6];
    assign tgt_ch  = i_write_data[7] ? i_write_data[6:5] : r_latch_ch;
    assign tgt_vol = i_write_data[7] ? i_write_data[4]   : r_latch_vol;

    always_comb begin
        n_atten      = r_atten;
        n_period     = r_period;
        n_noise_ctrl = r_noise_ctrl;
        n_latch_ch   = r_latch_ch;
        n_latch_vol  = r_latch_vol;
        if (wr) begin
            if (i_write_data[7]) begin
                n_latch_ch  = i_write_data[6:5];
                n_latch_vol = i_write_data[4];
            end
            if (tgt_vol) begin
                n_atten[tgt_ch] = i_write_data[3:0];
            end else if (tgt_ch == psg_pkg::NOISE_CH) begin
                n_noise_ctrl = i_write_data[2:0];
            end else if (i_write_data[7]) begin
                n_period[tgt_ch][3:0] = i_write_data[3:0];
            end else begin
                n_period[tgt_ch][9:4] = i_write_data[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atten      <= {psg_pkg::NUM_CHANS{psg_pkg::ATTEN_RESET}};
            r_period     <= {psg_pkg::NUM_TONES{psg_pkg::PERIOD_RESET}};
            r_noise_ctrl <= psg_pkg::NOISE_CTRL_RESET;
            r_latch_ch   <= 2'd0;
            r_latch_vol  <= 1'b0;
        end else if (i_en) begin
            r_atten      <= n_atten;
            r_period     <= n_period;
            r_noise_ctrl <= n_noise_ctrl;
            r_latch_ch   <= n_latch_ch;
            r_latch_vol  <= n_latch_vol;
        end
    end

    // The counters reload from the values that include this tick's write.
    assign o_cfg_next.period     = n_period;
    assign o_cfg_next.noise_ctrl = n_noise_ctrl;
    assign o_noise_ctrl          = r_noise_ctrl;
    assign o_atten               = r_atten;

endmodule

`default_nettype wire

[rtl/psg_counters.sv]
// Tone and noise down counters with their polarities, and the noise step index that advances every tick.
// Depends on psg_pkg.
`default_nettype none

module psg_counters #(
    parameter logic [15:0] NOISE_START = 16'd0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  psg_pkg::t_gen_cfg                 i_cfg,
    output logic [psg_pkg::NUM_CHANS-1:0]     o_polarity,
    output logic [15:0]                       o_noise_step
);

    logic [psg_pkg::NUM_CHANS-1:0][15:0] r_cnt, n_cnt;
    logic [psg_pkg::NUM_CHANS-1:0]       r_pol, n_pol;
    logic [15:0]                         r_pos;
    logic [psg_pkg::NUM_CHANS-1:0][15:0] dec;
    logic [15:0]                         noise_reload;

    always_comb begin
        case (i_cfg.noise_ctrl[1:0])
            psg_pkg::NOISE_RATE_16: noise_reload = 16'h0010;
            psg_pkg::NOISE_RATE_32: noise_reload = 16'h0020;
            psg_pkg::NOISE_RATE_64: noise_reload = 16'h0040;
            psg_pkg::NOISE_RATE_T2: noise_reload = {6'd0, i_cfg.period[2]};
            default:                noise_reload = {6'd0, i_cfg.period[2]};
        endcase
    end

    always_comb begin
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            dec[i]   = r_cnt[i] - 16'd1;
            n_cnt[i] = dec[i];
            n_pol[i] = r_pol[i];
            if (dec[i] == 16'd0) begin
                n_pol[i] = !r_pol[i];
                n_cnt[i] = {6'd0, i_cfg.period[i]};
            end
        end
        dec[psg_pkg::NOISE_CH]   = r_cnt[psg_pkg::NOISE_CH] - 16'd1;
        n_cnt[psg_pkg::NOISE_CH] = dec[psg_pkg::NOISE_CH];
        n_pol[psg_pkg::NOISE_CH] = r_pol[psg_pkg::NOISE_CH];
        if (dec[psg_pkg::NOISE_CH] == 16'd0) begin
            n_pol[psg_pkg::NOISE_CH] = !r_pol[psg_pkg::NOISE_CH];
            n_cnt[psg_pkg::NOISE_CH] = noise_reload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= {psg_pkg::NUM_CHANS{psg_pkg::COUNT_RESET}};
            r_pol <= '1;
            r_pos <= NOISE_START;
        end else if (i_en) begin
            r_cnt <= n_cnt;
            r_pol <= n_pol;
            r_pos <= r_pos + 16'd1;
        end
    end

    assign o_polarity   = r_pol;
    assign o_noise_step = r_pos;

endmodule

`default_nettype wire

[rtl/psg_rate.sv]
// Clock ratio register and fractional sample rate accumulator.
// Depends on psg_pkg.
`default_nettype none

module psg_rate (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_ratio_we,
    input  wire logic [19:0] i_ratio_data,
    output logic [19:0]      o_ratio,
    output logic             o_due
);

    logic [19:0] r_ratio;
    logic [20:0] r_acc;
    logic        r_due;
    logic [20:0] sum;
    logic        hit;

    assign sum = r_acc + psg_pkg::RATE_STEP;
    assign hit = sum >= {1'b0, r_ratio};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= psg_pkg::RATIO_RESET;
            r_acc   <= 21'd0;
            r_due   <= 1'b0;
        end else if (i_ratio_we) begin
            // A new ratio restarts the sample phase.
            r_ratio <= i_ratio_data;
            r_acc   <= 21'd0;
        end else if (i_en) begin
            r_due <= hit;
            if (hit) begin
                r_acc <= 21'({1'b0, sum[6:0]} + {1'b0, r_ratio[6:0]});
            end else begin
                r_acc <= sum;
            end
        end
    end

    assign o_ratio = r_ratio;
    assign o_due   = r_due;

endmodule

`default_nettype wire

[rtl/psg_tone_noise_core.sv]
// Four-channel tone and noise generator core: one request is one generator clock tick,
// possibly carrying a bus write, and yields one result with the state after that tick.
// Depends on psg_pkg, psg_regs, psg_counters, psg_rate and the assertion macro header.
//
// Each accepted request first lands in an input register. From there a single pass of
// short logic applies the optional bus write (latch byte or data byte, qualified by
// write_n and ioreq_n low and port address bit 6 set), steps the three tone counters
// and the noise counter, advances the noise step index and the sample rate accumulator,
// and stores the new state. The state registers themselves are the result register,
// so the result stays put while the downstream side stalls, and the input register
// takes the next request meanwhile. The block sustains one request per clock while the
// result side does not stall; a request passes through the input register into the
// state registers, which show its result. Period writes take effect
// in the same tick, so a counter that reloads in that tick already uses the new period.
// The sample ratio register sits at word 0 of the APB port; writing it also
// restarts the sample accumulator and is meant for when no request is in flight.
// There is no clearing pass after reset: the block accepts requests right away.
`default_nettype none

`include "psg_tone_noise_core_defines.svh"

module psg_tone_noise_core #(
    parameter logic [15:0] NOISE_START = 16'd0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Request channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_write_n,
    input  wire logic        i_ioreq_n,
    input  wire logic [7:0]  i_port_address,
    input  wire logic [7:0]  i_write_data,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_sample_due,
    output logic             o_tone0_level,
    output logic             o_tone1_level,
    output logic             o_tone2_level,
    output logic             o_noise_gate,
    output logic [3:0]       o_atten0,
    output logic [3:0]       o_atten1,
    output logic [3:0]       o_atten2,
    output logic [3:0]       o_atten3,
    output logic [15:0]      o_noise_step
);

    // Input register.
    logic       r_in_valid, n_in_valid;
    logic       r_write_n;
    logic       r_ioreq_n;
    logic [7:0] r_port_address;
    logic [7:0] r_write_data;
    logic       r_out_valid, n_out_valid;

    logic       in_take;
    logic       adv;
    logic       ratio_we;

    psg_pkg::t_gen_cfg                  cfg_next;
    logic [2:0]                         noise_ctrl;
    logic [psg_pkg::NUM_CHANS-1:0][3:0] atten;
    logic [psg_pkg::NUM_CHANS-1:0]      polarity;
    logic [19:0]                        ratio;

    // The held request moves into the state when the result slot is empty or being taken.
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_write_n      <= i_write_n;
            r_ioreq_n      <= i_ioreq_n;
            r_port_address <= i_port_address;
            r_write_data   <= i_write_data;
        end
    end

    // Configuration port: zero wait states, one register at word 0.
    assign pready   = 1'b1;
    assign ratio_we = psel && penable && pwrite && (paddr[2] == psg_pkg::REG_SAMPLE_RATIO);
    assign prdata   = (paddr[2] == psg_pkg::REG_SAMPLE_RATIO) ? {12'd0, ratio} : 32'd0;

    psg_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_write_n      (r_write_n),
        .i_ioreq_n      (r_ioreq_n),
        .i_port_address (r_port_address),
        .i_write_data   (r_write_data),
        .o_cfg_next     (cfg_next),
        .o_noise_ctrl   (noise_ctrl),
        .o_atten        (atten)
    );

    psg_counters #(
        .NOISE_START (NOISE_START)
    ) u_counters (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_cfg        (cfg_next),
        .o_polarity   (polarity),
        .o_noise_step (o_noise_step)
    );

    psg_rate u_rate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_ratio_we   (ratio_we),
        .i_ratio_data (pwdata[19:0]),
        .o_ratio      (ratio),
        .o_due        (o_sample_due)
    );

    assign o_out_valid   = r_out_valid;
    assign o_tone0_level = polarity[0];
    assign o_tone1_level = polarity[1];
    assign o_tone2_level = polarity[2];
    // White-noise mode keeps the noise gate open regardless of the noise polarity.
    assign o_noise_gate  = noise_ctrl[2] | polarity[3];
    assign o_atten0      = atten[0];
    assign o_atten1      = atten[1];
    assign o_atten2      = atten[2];
    assign o_atten3      = atten[3];

    // A tick that moves into the state always produces a visible result.
    `PSG_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, adv, r_out_valid)
    // The request side is only held off while a request waits in the input register.
    `PSG_ASSERT_NOW(a_stall_needs_held, i_clk, i_rst_n, o_in_stall, r_in_valid)
    // A held request that cannot advance is still there in the next cycle.
    `PSG_ASSERT_NEXT(a_held_kept, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid)
    // Every tick advances the noise step by exactly one.
    `PSG_ASSERT_NEXT(a_step_count, i_clk, i_rst_n, adv,
        o_noise_step == 16'($past(o_noise_step) + 16'd1))

endmodule

`default_nettype wire

[tb/tb_psg_tone_noise_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for psg_tone_noise_core: generator ticks with bus writes go in,
// each tick result is predicted here and compared field by field. Depends on psg_pkg and psg_tone_noise_core.

module tb_psg_tone_noise_core;

    localparam logic [15:0] NOISE_START_VAL = 16'd0;
    localparam int          LIMIT_CYCLES    = 200000;
    localparam int          LONG_HOLD       = 60;

    // Noise counter reload values for the three fixed noise rates.
    localparam logic [15:0] NOISE_RELOAD_16 = 16'h0010;
    localparam logic [15:0] NOISE_RELOAD_32 = 16'h0020;
    localparam logic [15:0] NOISE_RELOAD_64 = 16'h0040;

    localparam logic [19:0] RATIO_MIN  = 20'd128;
    localparam logic [19:0] RATIO_MAX  = 20'hfffff;
    localparam logic [2:0]  RATIO_ADDR = {psg_pkg::REG_SAMPLE_RATIO, 2'b00};

    // Address bit that selects this device on the IO bus.
    localparam logic [7:0]  DEV_SELECT = 8'h40;

    // One tick result as the block shows it.
    typedef struct packed {
        logic        sample_due;
        logic        tone0;
        logic        tone1;
        logic        tone2;
        logic        noise_gate;
        logic [3:0]  atten0;
        logic [3:0]  atten1;
        logic [3:0]  atten2;
        logic [3:0]  atten3;
        logic [15:0] noise_step;
    } t_tick_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_write_n;
    logic        i_ioreq_n;
    logic [7:0]  i_port_address;
    logic [7:0]  i_write_data;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_sample_due;
    logic        o_tone0_level;
    logic        o_tone1_level;
    logic        o_tone2_level;
    logic        o_noise_gate;
    logic [3:0]  o_atten0;
    logic [3:0]  o_atten1;
    logic [3:0]  o_atten2;
    logic [3:0]  o_atten3;
    logic [15:0] o_noise_step;

    psg_tone_noise_core #(
        .NOISE_START (NOISE_START_VAL)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_write_n      (i_write_n),
        .i_ioreq_n      (i_ioreq_n),
        .i_port_address (i_port_address),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_due   (o_sample_due),
        .o_tone0_level  (o_tone0_level),
        .o_tone1_level  (o_tone1_level),
        .o_tone2_level  (o_tone2_level),
        .o_noise_gate   (o_noise_gate),
        .o_atten0       (o_atten0),
        .o_atten1       (o_atten1),
        .o_atten2       (o_atten2),
        .o_atten3       (o_atten3),
        .o_noise_step   (o_noise_step)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Generator predictor. It holds its own copy of every register and
    // counter of the block and steps it once per accepted request.
    // ------------------------------------------------------------------
    logic [3:0]  vol_atten [0:3];
    logic [9:0]  tone_period [0:2];
    logic [2:0]  noise_ctrl;
    logic [15:0] down_cnt [0:3];
    logic        level [0:3];
    logic [15:0] noise_pos;
    logic [1:0]  latch_ch;
    logic        latch_is_vol;
    logic [20:0] rate_acc;
    logic [19:0] ratio;

    t_tick_result tick_results_q[$];
    int           errors = 0;

    task automatic reset_generator();
        for (int i = 0; i < psg_pkg::NUM_CHANS; i++) begin
            vol_atten[i] = psg_pkg::ATTEN_RESET;
            down_cnt[i]  = psg_pkg::COUNT_RESET;
            level[i]     = 1'b1;
        end
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            tone_period[i] = psg_pkg::PERIOD_RESET;
        end
        noise_ctrl   = psg_pkg::NOISE_CTRL_RESET;
        noise_pos    = NOISE_START_VAL;
        latch_ch     = 2'd0;
        latch_is_vol = 1'b0;
        rate_acc     = '0;
        ratio        = psg_pkg::RATIO_RESET;
    endtask

    // Advances the generator by one tick and returns what the block must show.
    task automatic predict_tick(input logic wn, input logic ion, input logic [7:0] addr,
                                input logic [7:0] data, output t_tick_result r);
        logic due;
        due = 1'b0;

        // A write counts only with both strobes low and the device address bit set.
        // A latch byte picks channel and register type and carries the low data bits;
        // a data byte goes to whatever register was latched last.
        if (!wn && !ion && addr[6]) begin
            if (data[7]) begin
                latch_ch     = data[6:5];
                latch_is_vol = data[4];
            end
            if (latch_is_vol) begin
                vol_atten[latch_ch] = data[3:0];
            end else if (latch_ch == psg_pkg::NOISE_CH) begin
                noise_ctrl = data[2:0];
            end else if (data[7]) begin
                tone_period[latch_ch][3:0] = data[3:0];
            end else begin
                tone_period[latch_ch][9:4] = data[5:0];
            end
        end

        // Tone counters reload after the write, so a new period applies this tick.
        // A zero period leaves the counter at zero and it wraps on the next tick.
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            down_cnt[i] = down_cnt[i] - 16'd1;
            if (down_cnt[i] == 16'd0) begin
                level[i]    = ~level[i];
                down_cnt[i] = {6'd0, tone_period[i]};
            end
        end

        down_cnt[psg_pkg::NOISE_CH] = down_cnt[psg_pkg::NOISE_CH] - 16'd1;
        noise_pos                   = noise_pos + 16'd1;
        if (down_cnt[psg_pkg::NOISE_CH] == 16'd0) begin
            level[psg_pkg::NOISE_CH] = ~level[psg_pkg::NOISE_CH];
            case (noise_ctrl[1:0])
                psg_pkg::NOISE_RATE_16: begin
                    down_cnt[psg_pkg::NOISE_CH] = NOISE_RELOAD_16;
                end
                psg_pkg::NOISE_RATE_32: begin
                    down_cnt[psg_pkg::NOISE_CH] = NOISE_RELOAD_32;
                end
                psg_pkg::NOISE_RATE_64: begin
                    down_cnt[psg_pkg::NOISE_CH] = NOISE_RELOAD_64;
                end
                default: begin
                    down_cnt[psg_pkg::NOISE_CH] = {6'd0, tone_period[2]};
                end
            endcase
        end

        // The accumulator keeps the fraction of a sample and adds the ratio's fraction.
        rate_acc = rate_acc + psg_pkg::RATE_STEP;
        if (rate_acc >= {1'b0, ratio}) begin
            rate_acc = {14'd0, rate_acc[6:0]} + {14'd0, ratio[6:0]};
            due      = 1'b1;
        end

        r.sample_due = due;
        r.tone0      = level[0];
        r.tone1      = level[1];
        r.tone2      = level[2];
        r.noise_gate = noise_ctrl[2] | level[psg_pkg::NOISE_CH];
        r.atten0     = vol_atten[0];
        r.atten1     = vol_atten[1];
        r.atten2     = vol_atten[2];
        r.atten3     = vol_atten[psg_pkg::NOISE_CH];
        r.noise_step = noise_pos;
    endtask

    // ------------------------------------------------------------------
    // Result checking: every accepted result is matched against the
    // oldest prediction still waiting.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tick_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tick_results_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual noise_step %h",
                         $time, o_noise_step);
                errors++;
            end else begin
                e = tick_results_q.pop_front();
                check_field("sample_due", 16'(e.sample_due), 16'(o_sample_due));
                check_field("tone0_level", 16'(e.tone0), 16'(o_tone0_level));
                check_field("tone1_level", 16'(e.tone1), 16'(o_tone1_level));
                check_field("tone2_level", 16'(e.tone2), 16'(o_tone2_level));
                check_field("noise_gate", 16'(e.noise_gate), 16'(o_noise_gate));
                check_field("atten0", 16'(e.atten0), 16'(o_atten0));
                check_field("atten1", 16'(e.atten1), 16'(o_atten1));
                check_field("atten2", 16'(e.atten2), 16'(o_atten2));
                check_field("atten3", 16'(e.atten3), 16'(o_atten3));
                check_field("noise_step", e.noise_step, o_noise_step);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side stall. A toggle of hold_toggle starts a long hold-off
    // counted here; otherwise short random bursts while enabled.
    // ------------------------------------------------------------------
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   stall_left  = 0;
    logic out_idle_en = 1'b1;
    logic in_idle_en;

    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen   <= hold_toggle;
            hold_left   <= LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
            stall_left  <= $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Run limit: a hang anywhere ends the run as a failure.
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[psg_tone_noise_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side. Every task starts and ends just after a rising edge.
    // ------------------------------------------------------------------

    // Offers one tick request, holds it until accepted, then records its prediction.
    task automatic send_request(input logic wn, input logic ion, input logic [7:0] addr,
                                input logic [7:0] data);
        t_tick_result r;
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_write_n      <= wn;
        i_ioreq_n      <= ion;
        i_port_address <= addr;
        i_write_data   <= data;
        do @(posedge i_clk); while (o_in_stall);
        predict_tick(wn, ion, addr, data, r);
        tick_results_q.push_back(r);
    endtask

    // Stops offering requests and waits until every predicted result has been seen.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tick_results_q.size() != 0);
    endtask

    // Writes the sample ratio through the APB port, then reads it back.
    // Only called while nothing is in flight.
    task automatic program_sample_ratio(input logic [19:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RATIO_ADDR;
        pwdata  <= {12'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ratio    = value;
        rate_acc = '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {12'd0, value}) begin
            $display("%0t: sample ratio readback mismatch, expected %h actual %h",
                     $time, {12'd0, value}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random traffic. Most requests are well-formed latch and data byte pairs with
    // random content; tone data bytes mostly carry small upper bits so that the tone
    // counters reload with short periods and toggle often. The rest is bus noise.
    task automatic send_random_items(input int total);
        int         sent;
        logic [1:0] ch;
        logic       vol;
        logic [5:0] upper;
        sent = 0;
        while (sent < total) begin
            if ($urandom_range(0, 9) < 7) begin
                ch    = 2'($urandom);
                vol   = 1'($urandom);
                upper = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 1));
                send_request(1'b0, 1'b0, 8'($urandom) | DEV_SELECT,
                             {1'b1, ch, vol, 4'($urandom)});
                send_request(1'b0, 1'b0, 8'($urandom) | DEV_SELECT,
                             {1'b0, 1'($urandom), upper});
                sent += 2;
            end else begin
                send_request(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    // Directed bus writes: every register type on every channel, both byte kinds,
    // all noise rates, zero tone periods, and writes that the strobes or the
    // address leave unqualified.
    task automatic test_bus_writes();
        send_request(1'b0, 1'b0, 8'h40, 8'h8f);  // tone 0 low bits all ones
        send_request(1'b0, 1'b0, 8'h7f, 8'h3f);  // data byte fills tone 0 upper bits
        send_request(1'b0, 1'b0, 8'hff, 8'ha0);  // tone 1 low bits zero
        send_request(1'b0, 1'b0, 8'h40, 8'h00);  // tone 1 period becomes zero
        send_request(1'b0, 1'b0, 8'h40, 8'hc3);  // tone 2 low bits
        send_request(1'b0, 1'b0, 8'h40, 8'h40);  // bit 6 of a data byte is not a latch
        send_request(1'b0, 1'b0, 8'h40, 8'he4);  // noise: white, rate 16
        send_request(1'b0, 1'b0, 8'h40, 8'h01);  // data byte to noise: rate 32
        send_request(1'b0, 1'b0, 8'h40, 8'he2);  // noise rate 64
        send_request(1'b0, 1'b0, 8'h40, 8'he7);  // noise follows tone 2, white
        send_request(1'b0, 1'b0, 8'h40, 8'h90);  // channel 0 loudest
        send_request(1'b0, 1'b0, 8'h40, 8'hbf);  // channel 1 silent
        send_request(1'b0, 1'b0, 8'h40, 8'hd5);
        send_request(1'b0, 1'b0, 8'h40, 8'hfa);
        send_request(1'b0, 1'b0, 8'h40, 8'h3c);  // data byte to volume keeps bits 3..0
        send_request(1'b1, 1'b0, 8'h40, 8'h9f);  // write strobe inactive
        send_request(1'b0, 1'b1, 8'h40, 8'h9f);  // IO strobe inactive
        send_request(1'b0, 1'b0, 8'hbf, 8'h9f);  // device address bit clear
        send_request(1'b1, 1'b1, 8'h00, 8'h00);
        send_request(1'b0, 1'b0, 8'h40, 8'he0);  // periodic noise, rate 16
        send_request(1'b0, 1'b0, 8'h40, 8'h80);
        send_request(1'b0, 1'b0, 8'h40, 8'h00);  // tone 0 period becomes zero
    endtask

    // Sample ratio extremes: the smallest ratio makes every tick a sample tick.
    task automatic test_sample_ratio_extremes();
        logic [19:0] ratios [0:2];
        ratios[0] = RATIO_MIN;
        ratios[1] = RATIO_MAX;
        ratios[2] = RATIO_MIN + 20'd1;
        for (int k = 0; k < 3; k++) begin
            wait_drain();
            program_sample_ratio(ratios[k]);
            repeat (8) send_request(1'b1, 1'b1, 8'($urandom), 8'($urandom));
        end
    endtask

    // Long result hold-off while requests keep coming, so the block backs up and
    // stalls its input; then the sender pauses until everything has drained.
    task automatic test_backpressure();
        wait_drain();
        hold_toggle <= ~hold_toggle;
        send_random_items(30);
        wait_drain();
        send_random_items(20);
    endtask

    // Several ratio settings with random traffic; idling is switched per phase and
    // the last phase runs with no idling at all.
    task automatic test_random_traffic();
        logic [19:0] r;
        for (int phase = 0; phase < 5; phase++) begin
            wait_drain();
            if (phase == 2) begin
                r = 20'($urandom_range(RATIO_MIN, RATIO_MAX));
            end else begin
                r = 20'($urandom_range(RATIO_MIN, 1500));
            end
            program_sample_ratio(r);
            in_idle_en   = (phase != 1) && (phase != 4);
            out_idle_en <= (phase != 2) && (phase != 4);
            send_random_items(270);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_write_n      = 1'b1;
        i_ioreq_n      = 1'b1;
        i_port_address = '0;
        i_write_data   = '0;
        in_idle_en     = 1'b1;
        reset_generator();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bus_writes();
        test_sample_ratio_extremes();
        test_backpressure();
        test_random_traffic();

        // Drain every predicted result before the final verdict.
        wait_drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("[psg_tone_noise_core] OK");
        end else begin
            $display("[psg_tone_noise_core] ERROR");
        end
        $finish;
    end

endmodule
